// ----- design/lphi_pkg.sv -----
// Shared types and constants for the linear-probe hash insert block.
// Used by the front, queue, back and top-level modules; no dependencies.
package lphi_pkg;

    localparam int SLOTS     = 1024;
    localparam int SLOT_W    = $clog2(SLOTS);
    localparam int CAP_W     = SLOT_W + 1;
    localparam int CFG_W     = 11;
    localparam int KEY_W     = 32;
    localparam int VAL_W     = 32;
    localparam int NUM_W     = 10;
    localparam int CNT_W     = 11;
    localparam int CMD_W     = 2;
    localparam int STAT_W    = 2;
    localparam int DIV_CNT_W = $clog2(KEY_W);
    localparam int QDEPTH    = 2;
    localparam int QPTR_W    = $clog2(QDEPTH);

    localparam logic [CMD_W-1:0] CMD_INSERT = 2'd0;
    localparam logic [CMD_W-1:0] CMD_READ   = 2'd1;
    localparam logic [CMD_W-1:0] CMD_CLEAR  = 2'd2;

    localparam logic [STAT_W-1:0] ST_OK    = 2'd0;
    localparam logic [STAT_W-1:0] ST_FULL  = 2'd1;
    localparam logic [STAT_W-1:0] ST_RANGE = 2'd2;

    // operation class decided by the front end
    typedef enum logic [2:0] {
        OP_NOP,
        OP_INSERT,
        OP_READ,
        OP_RANGE,
        OP_CLEAR
    } op_t;

    typedef struct packed {
        op_t              op;
        logic [SLOT_W-1:0] addr;
        logic [VAL_W-1:0]  va;
        logic [VAL_W-1:0]  vb;
    } q_item_t;

    typedef struct packed {
        logic empty;
        logic full;
    } q_status_t;

    typedef struct packed {
        logic             valid;
        logic [VAL_W-1:0] va;
        logic [VAL_W-1:0] vb;
        logic [NUM_W-1:0] num;
    } slot_entry_t;

    typedef struct packed {
        logic [STAT_W-1:0] status;
        logic [SLOT_W-1:0] slot;
        logic [CAP_W-1:0]  probes;
        logic              occupied;
        logic [VAL_W-1:0]  va;
        logic [VAL_W-1:0]  vb;
        logic [NUM_W-1:0]  num;
    } result_t;

endpackage

// ----- design/lphi_front.sv -----
// Front end: accepts commands, classifies them and computes the home slot
// with a bit-serial remainder unit. Depends on lphi_pkg.
module lphi_front (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       start,
    input  logic [lphi_pkg::CMD_W-1:0]  cmd,
    input  logic [lphi_pkg::KEY_W-1:0]  hash_key,
    input  logic [lphi_pkg::VAL_W-1:0]  value_a,
    input  logic [lphi_pkg::VAL_W-1:0]  value_b,
    input  logic [lphi_pkg::SLOT_W-1:0] read_slot,
    input  logic [lphi_pkg::CAP_W-1:0]  cap,
    input  logic                       back_init,
    input  lphi_pkg::q_status_t         q_stat,
    output logic                       busy,
    output logic                       push,
    output lphi_pkg::q_item_t           push_item
);
    import lphi_pkg::*;

    typedef enum logic [1:0] {
        F_IDLE,
        F_DIV,
        F_PUSH
    } fstate_t;

    fstate_t               state_reg, state_next;
    logic [KEY_W-1:0]      key_reg, key_next;
    logic [SLOT_W-1:0]     rem_reg, rem_next;
    logic [DIV_CNT_W-1:0]  cnt_reg, cnt_next;
    q_item_t               item_reg, item_next;

    logic [CAP_W-1:0]      trial;
    logic [SLOT_W-1:0]     rem_step;

    // one restoring step: remainder stays below cap, so trial < 2*cap
    always_comb
    begin
        trial    = {rem_reg, key_reg[KEY_W-1]};
        rem_step = (trial >= cap) ? SLOT_W'(trial - cap) : trial[SLOT_W-1:0];
    end

    assign busy      = (state_reg != F_IDLE) || back_init;
    assign push      = (state_reg == F_PUSH) && !q_stat.full;
    assign push_item = item_reg;

    always_comb
    begin
        state_next = state_reg;
        key_next   = key_reg;
        rem_next   = rem_reg;
        cnt_next   = cnt_reg;
        item_next  = item_reg;
        unique case (state_reg)
            F_IDLE:
            begin
                if (start && !back_init)
                begin
                    item_next.va   = value_a;
                    item_next.vb   = value_b;
                    item_next.addr = read_slot;
                    unique case (cmd)
                        CMD_INSERT:
                        begin
                            item_next.op = OP_INSERT;
                            key_next     = hash_key;
                            rem_next     = '0;
                            cnt_next     = DIV_CNT_W'(KEY_W - 1);
                            state_next   = F_DIV;
                        end
                        CMD_READ:
                        begin
                            item_next.op = ({1'b0, read_slot} >= cap) ? OP_RANGE : OP_READ;
                            state_next   = F_PUSH;
                        end
                        CMD_CLEAR:
                        begin
                            item_next.op = OP_CLEAR;
                            state_next   = F_PUSH;
                        end
                        default:
                        begin
                            item_next.op = OP_NOP;
                            state_next   = F_PUSH;
                        end
                    endcase
                end
            end
            F_DIV:
            begin
                key_next = key_reg << 1;
                rem_next = rem_step;
                cnt_next = cnt_reg - 1'b1;
                if (cnt_reg == '0)
                begin
                    item_next.addr = rem_step;
                    state_next     = F_PUSH;
                end
            end
            F_PUSH:
            begin
                if (!q_stat.full)
                begin
                    state_next = F_IDLE;
                end
            end
            default:
            begin
                state_next = F_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= F_IDLE;
            cnt_reg   <= '0;
            item_reg  <= '0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
            item_reg  <= item_next;
        end
    end

    always_ff @(posedge clk)
    begin
        key_reg  <= key_next;
        rem_reg  <= rem_next;
    end

endmodule

// ----- design/lphi_queue.sv -----
// Short FIFO between the front end and the table engine.
// Depends on lphi_pkg.
module lphi_queue (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               push,
    input  lphi_pkg::q_item_t   push_item,
    input  logic               pop,
    output lphi_pkg::q_item_t   head,
    output lphi_pkg::q_status_t q_stat
);
    import lphi_pkg::*;

    q_item_t            slots_reg [QDEPTH];
    logic [QPTR_W-1:0]  wr_ptr_reg, rd_ptr_reg;
    logic [QPTR_W:0]    count_reg, count_next;

    assign head         = slots_reg[rd_ptr_reg];
    assign q_stat.empty = (count_reg == '0);
    assign q_stat.full  = (count_reg == (QPTR_W + 1)'(QDEPTH));

    always_comb
    begin
        count_next = count_reg;
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            count_reg <= count_next;
            if (push)
            begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slots_reg[wr_ptr_reg] <= push_item;
        end
    end

endmodule

// ----- design/lphi_back.sv -----
// Table engine: slot memory, linear probing, reads, clear and reset sweeps.
// Depends on lphi_pkg.
module lphi_back (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic [lphi_pkg::CAP_W-1:0] cap,
    input  lphi_pkg::q_item_t          head,
    input  lphi_pkg::q_status_t        q_stat,
    output logic                      pop,
    output logic                      init_busy,
    output logic                      done,
    output lphi_pkg::result_t          res
);
    import lphi_pkg::*;

    typedef enum logic [2:0] {
        S_INIT,
        S_IDLE,
        S_WAIT,
        S_CHECK,
        S_CLEAR
    } bstate_t;

    bstate_t            state_reg, state_next;
    logic [SLOT_W-1:0]  addr_reg, addr_next;
    logic [CAP_W-1:0]   probes_reg, probes_next;
    logic [CNT_W-1:0]   count_reg, count_next;
    op_t                op_reg, op_next;
    logic [VAL_W-1:0]   va_reg, va_next;
    logic [VAL_W-1:0]   vb_reg, vb_next;
    logic               done_reg, done_next;
    result_t            res_reg, res_next;

    slot_entry_t        mem [SLOTS];
    slot_entry_t        rd_reg;
    logic               mem_we;
    slot_entry_t        mem_wd;

    logic [CAP_W-1:0]   addr_inc;
    logic [SLOT_W-1:0]  addr_wrap;
    logic               sweep_last;

    assign pop       = (state_reg == S_IDLE) && !q_stat.empty;
    assign init_busy = (state_reg == S_INIT);
    assign done      = done_reg;
    assign res       = res_reg;

    always_comb
    begin
        addr_inc   = {1'b0, addr_reg} + 1'b1;
        addr_wrap  = (addr_inc == cap) ? '0 : addr_inc[SLOT_W-1:0];
        sweep_last = (addr_reg == SLOT_W'(SLOTS - 1));
    end

    always_comb
    begin
        state_next  = state_reg;
        addr_next   = addr_reg;
        probes_next = probes_reg;
        count_next  = count_reg;
        op_next     = op_reg;
        va_next     = va_reg;
        vb_next     = vb_reg;
        done_next   = 1'b0;
        res_next    = '0;
        mem_we      = 1'b0;
        mem_wd      = '0;
        unique case (state_reg)
            S_INIT, S_CLEAR:
            begin
                mem_we    = 1'b1;
                addr_next = addr_reg + 1'b1;
                if (sweep_last)
                begin
                    state_next = S_IDLE;
                    if (state_reg == S_CLEAR)
                    begin
                        count_next = '0;
                        done_next  = 1'b1;
                    end
                end
            end
            S_IDLE:
            begin
                if (!q_stat.empty)
                begin
                    op_next = head.op;
                    va_next = head.va;
                    vb_next = head.vb;
                    unique case (head.op)
                        OP_INSERT, OP_READ:
                        begin
                            addr_next   = head.addr;
                            probes_next = CAP_W'(1);
                            state_next  = S_WAIT;
                        end
                        OP_RANGE:
                        begin
                            done_next       = 1'b1;
                            res_next.status = ST_RANGE;
                            res_next.slot   = head.addr;
                        end
                        OP_CLEAR:
                        begin
                            addr_next  = '0;
                            state_next = S_CLEAR;
                        end
                        default:
                        begin
                            done_next = 1'b1;
                        end
                    endcase
                end
            end
            S_WAIT:
            begin
                state_next = S_CHECK;
            end
            S_CHECK:
            begin
                if (op_reg == OP_READ)
                begin
                    done_next         = 1'b1;
                    state_next        = S_IDLE;
                    res_next.slot     = addr_reg;
                    res_next.occupied = rd_reg.valid;
                    if (rd_reg.valid)
                    begin
                        res_next.va  = rd_reg.va;
                        res_next.vb  = rd_reg.vb;
                        res_next.num = rd_reg.num;
                    end
                end
                else if (!rd_reg.valid)
                begin
                    mem_we          = 1'b1;
                    mem_wd.valid    = 1'b1;
                    mem_wd.va       = va_reg;
                    mem_wd.vb       = vb_reg;
                    mem_wd.num      = count_reg[NUM_W-1:0];
                    count_next      = count_reg + 1'b1;
                    done_next       = 1'b1;
                    state_next      = S_IDLE;
                    res_next.slot   = addr_reg;
                    res_next.probes = probes_reg;
                    res_next.num    = count_reg[NUM_W-1:0];
                end
                else if (probes_reg == cap)
                begin
                    done_next       = 1'b1;
                    state_next      = S_IDLE;
                    res_next.status = ST_FULL;
                    res_next.probes = cap;
                end
                else
                begin
                    probes_next = probes_reg + 1'b1;
                    addr_next   = addr_wrap;
                    state_next  = S_WAIT;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_INIT;
            addr_reg  <= '0;
            count_reg <= '0;
            op_reg    <= OP_NOP;
            done_reg  <= 1'b0;
            res_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            addr_reg  <= addr_next;
            count_reg <= count_next;
            op_reg    <= op_next;
            done_reg  <= done_next;
            res_reg   <= res_next;
        end
    end

    always_ff @(posedge clk)
    begin
        probes_reg <= probes_next;
        va_reg     <= va_next;
        vb_reg     <= vb_next;
    end

    // slot memory: one write port, one registered read port
    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[addr_reg] <= mem_wd;
        end
        rd_reg <= mem[addr_reg];
    end

`ifndef ASSERT_OFF
    property p_full_probes;
        @(posedge clk) disable iff (!rst_n)
        (done_reg && (res_reg.status == ST_FULL)) |-> (res_reg.probes == cap);
    endproperty
    a_full_probes: assert property (p_full_probes)
        else $error("full result with probe count other than capacity");

    property p_occ_ok;
        @(posedge clk) disable iff (!rst_n)
        (done_reg && res_reg.occupied) |-> (res_reg.status == ST_OK);
    endproperty
    a_occ_ok: assert property (p_occ_ok)
        else $error("occupied flag with non-ok status");

    property p_init_quiet;
        @(posedge clk) disable iff (!rst_n)
        (state_reg == S_INIT) |-> (!done_reg && !pop);
    endproperty
    a_init_quiet: assert property (p_init_quiet)
        else $error("transfer during reset sweep");

    property p_insert_done;
        @(posedge clk) disable iff (!rst_n)
        (mem_we && (state_reg == S_CHECK)) |=> (done_reg && (res_reg.status == ST_OK));
    endproperty
    a_insert_done: assert property (p_insert_done)
        else $error("slot written without an ok result");
`endif

endmodule

// ----- design/linear_probe_hash_insert_top.sv -----
// Top level of the linear-probe hash insert block: APB capacity register,
// front end, queue and table engine. Depends on lphi_pkg and all lphi_* modules.
// Insert: the front end's 32-step remainder unit computes the home slot, and the
// front end takes no new command until it has pushed the previous one to the queue.
// Each probed slot passes through S_WAIT and S_CHECK (registered read of the slot memory).
// A clear sweeps the whole table one slot per cycle.
// After reset busy stays high while the table is swept empty.
// Results are strobed on done for one cycle; the receiver cannot stall.
module linear_probe_hash_insert_top (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        start,
    output logic                        busy,
    input  logic [lphi_pkg::CMD_W-1:0]   cmd,
    input  logic [lphi_pkg::KEY_W-1:0]   hash_key,
    input  logic [lphi_pkg::VAL_W-1:0]   value_a,
    input  logic [lphi_pkg::VAL_W-1:0]   value_b,
    input  logic [lphi_pkg::SLOT_W-1:0]  read_slot,
    output logic                        done,
    output logic [lphi_pkg::STAT_W-1:0]  status,
    output logic [lphi_pkg::SLOT_W-1:0]  slot,
    output logic [lphi_pkg::CAP_W-1:0]   probes,
    output logic                        occupied,
    output logic [lphi_pkg::VAL_W-1:0]   out_value_a,
    output logic [lphi_pkg::VAL_W-1:0]   out_value_b,
    output logic [lphi_pkg::NUM_W-1:0]   entry_number,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [2:0]                  paddr,
    input  logic [31:0]                 pwdata,
    output logic [31:0]                 prdata,
    output logic                        pready
);
    import lphi_pkg::*;

    localparam logic REG_CAPACITY = 1'b0;

    logic [CFG_W-1:0] cap_cfg_reg;
    logic [CAP_W-1:0] eff_cap;
    logic             cfg_wr;

    q_item_t          push_item;
    q_item_t          head;
    q_status_t        q_stat;
    logic             push;
    logic             pop;
    logic             back_init;
    result_t          res;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready;
    assign prdata = (paddr[2] == REG_CAPACITY) ? 32'(cap_cfg_reg) : '0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cap_cfg_reg <= CFG_W'(1024);
        end
        else if (cfg_wr && (paddr[2] == REG_CAPACITY))
        begin
            cap_cfg_reg <= pwdata[CFG_W-1:0];
        end
    end

    // capacity clamped to 1..SLOTS
    always_comb
    begin
        priority if (cap_cfg_reg == '0)
        begin
            eff_cap = CAP_W'(1);
        end
        else if (int'(cap_cfg_reg) > SLOTS)
        begin
            eff_cap = CAP_W'(SLOTS);
        end
        else
        begin
            eff_cap = CAP_W'(cap_cfg_reg);
        end
    end

    lphi_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (start),
        .cmd       (cmd),
        .hash_key  (hash_key),
        .value_a   (value_a),
        .value_b   (value_b),
        .read_slot (read_slot),
        .cap       (eff_cap),
        .back_init (back_init),
        .q_stat    (q_stat),
        .busy      (busy),
        .push      (push),
        .push_item (push_item)
    );

    lphi_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_item (push_item),
        .pop       (pop),
        .head      (head),
        .q_stat    (q_stat)
    );

    lphi_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cap       (eff_cap),
        .head      (head),
        .q_stat    (q_stat),
        .pop       (pop),
        .init_busy (back_init),
        .done      (done),
        .res       (res)
    );

    assign status       = res.status;
    assign slot         = res.slot;
    assign probes       = res.probes;
    assign occupied     = res.occupied;
    assign out_value_a  = res.va;
    assign out_value_b  = res.vb;
    assign entry_number = res.num;

endmodule

// ----- tb/tb_linear_probe_hash_insert_top.sv -----
// Self-checking testbench for linear_probe_hash_insert_top: directed and random
// insert/read/clear traffic with capacity changes over APB, checked against a local table model.
// Depends on lphi_pkg and the linear_probe_hash_insert_top RTL.
`timescale 1ns / 100ps

module tb_linear_probe_hash_insert_top;

    import lphi_pkg::*;

    localparam logic [CMD_W-1:0] CMD_UNUSED    = 2'd3;
    localparam logic [2:0]       ADDR_CAPACITY = 3'd0;
    localparam int               MAX_CYCLES    = 1_000_000;
    localparam int               PHASE_ITEMS   = 55;

    logic              clk = 1'b0;
    logic              rst_n;
    logic              start;
    logic              busy;
    logic [CMD_W-1:0]  cmd;
    logic [KEY_W-1:0]  hash_key;
    logic [VAL_W-1:0]  value_a;
    logic [VAL_W-1:0]  value_b;
    logic [SLOT_W-1:0] read_slot;
    logic              done;
    logic [STAT_W-1:0] status;
    logic [SLOT_W-1:0] slot;
    logic [CAP_W-1:0]  probes;
    logic              occupied;
    logic [VAL_W-1:0]  out_value_a;
    logic [VAL_W-1:0]  out_value_b;
    logic [NUM_W-1:0]  entry_number;
    logic              psel;
    logic              penable;
    logic              pwrite;
    logic [2:0]        paddr;
    logic [31:0]       pwdata;
    logic [31:0]       prdata;
    logic              pready;

    // local copy of the table and its register
    bit                tbl_valid [SLOTS];
    logic [VAL_W-1:0]  tbl_va    [SLOTS];
    logic [VAL_W-1:0]  tbl_vb    [SLOTS];
    logic [NUM_W-1:0]  tbl_num   [SLOTS];
    logic [CNT_W-1:0]  ins_count = '0;
    logic [CFG_W-1:0]  cap_reg   = 11'd1024;

    result_t predicted_results [$];
    result_t observed;
    result_t wanted;
    int      result_errors   = 0;
    int      cycle_count     = 0;
    int      sender_idle_pct = 27;

    linear_probe_hash_insert_top u_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .start        (start),
        .busy         (busy),
        .cmd          (cmd),
        .hash_key     (hash_key),
        .value_a      (value_a),
        .value_b      (value_b),
        .read_slot    (read_slot),
        .done         (done),
        .status       (status),
        .slot         (slot),
        .probes       (probes),
        .occupied     (occupied),
        .out_value_a  (out_value_a),
        .out_value_b  (out_value_b),
        .entry_number (entry_number),
        .psel         (psel),
        .penable      (penable),
        .pwrite       (pwrite),
        .paddr        (paddr),
        .pwdata       (pwdata),
        .prdata       (prdata),
        .pready       (pready)
    );

    always #5 clk = ~clk;

    function automatic int unsigned effective_capacity();
        if (cap_reg == '0)
            return 1;
        if (cap_reg > SLOTS)
            return SLOTS;
        return cap_reg;
    endfunction

    // Applies one command to the local table and returns the result it should give.
    function automatic result_t hash_table_op(input logic [CMD_W-1:0] c,
                                              input logic [KEY_W-1:0] key,
                                              input logic [VAL_W-1:0] a,
                                              input logic [VAL_W-1:0] b,
                                              input logic [SLOT_W-1:0] rs);
        result_t     r;
        int unsigned cap;
        int unsigned k;
        int unsigned n;
        r   = '0;
        cap = effective_capacity();
        case (c)
            CMD_INSERT:
            begin
                k = key % cap;
                n = 1;
                while (n <= cap && tbl_valid[k])
                begin
                    k = (k + 1 == cap) ? 0 : k + 1;
                    n++;
                end
                if (n <= cap)
                begin
                    tbl_valid[k] = 1'b1;
                    tbl_va[k]    = a;
                    tbl_vb[k]    = b;
                    tbl_num[k]   = ins_count[NUM_W-1:0];
                    r.slot       = k[SLOT_W-1:0];
                    r.probes     = n[CAP_W-1:0];
                    r.num        = ins_count[NUM_W-1:0];
                    ins_count    = ins_count + 1'b1;
                end
                else
                begin
                    r.status = ST_FULL;
                    r.probes = cap[CAP_W-1:0];
                end
            end
            CMD_READ:
            begin
                r.slot = rs;
                if (rs >= cap)
                    r.status = ST_RANGE;
                else if (tbl_valid[rs])
                begin
                    r.occupied = 1'b1;
                    r.va       = tbl_va[rs];
                    r.vb       = tbl_vb[rs];
                    r.num      = tbl_num[rs];
                end
            end
            CMD_CLEAR:
            begin
                foreach (tbl_valid[i])
                    tbl_valid[i] = 1'b0;
                ins_count = '0;
            end
            default:
            begin
            end
        endcase
        return r;
    endfunction

    function automatic string show_result(input result_t r);
        return $sformatf("st=%0d slot=%0d probes=%0d occ=%0d a=%h b=%h num=%0d",
                         r.status, r.slot, r.probes, r.occupied, r.va, r.vb, r.num);
    endfunction

    task automatic send_item(input logic [CMD_W-1:0] c, input logic [KEY_W-1:0] key,
                             input logic [VAL_W-1:0] a, input logic [VAL_W-1:0] b,
                             input logic [SLOT_W-1:0] rs);
        int gap;
        gap = 0;
        while (gap < 12 && $urandom_range(0, 99) < sender_idle_pct)
            gap++;
        if (gap > 0)
        begin
            start <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        start     <= 1'b1;
        cmd       <= c;
        hash_key  <= key;
        value_a   <= a;
        value_b   <= b;
        read_slot <= rs;
        do
            @(negedge clk);
        while (busy);
        @(posedge clk);
        // transfer taken at this edge
        predicted_results.push_back(hash_table_op(c, key, a, b, rs));
    endtask

    // Holds off until every predicted result has arrived and the block is free.
    task automatic wait_idle();
        start <= 1'b0;
        do
            @(negedge clk);
        while (busy || predicted_results.size() != 0);
        @(posedge clk);
    endtask

    task automatic write_capacity(input logic [CFG_W-1:0] val);
        wait_idle();
        psel    <= 1'b1;
        pwrite  <= 1'b1;
        penable <= 1'b0;
        paddr   <= ADDR_CAPACITY;
        pwdata  <= {{(32-CFG_W){1'b0}}, val};
        @(posedge clk);
        penable <= 1'b1;
        do
            @(negedge clk);
        while (!pready);
        @(posedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        cap_reg = val;
    endtask

    task automatic test_empty_reads();
        send_item(CMD_READ, '0, '0, '0, 10'd0);
        send_item(CMD_READ, '0, '0, '0, 10'd1023);
    endtask

    task automatic test_probe_wrap();
        send_item(CMD_INSERT, 32'd0, 32'h0, 32'h0, 10'd0);
        send_item(CMD_INSERT, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 10'h3FF);
        send_item(CMD_INSERT, 32'd1024, 32'hA5A5_5A5A, $urandom, 10'd0);
        // home is the last slot, taken; wraps past slots 0 and 1
        send_item(CMD_INSERT, 32'hFFFF_FFFF, $urandom, $urandom, 10'd0);
        send_item(CMD_READ, '0, '0, '0, 10'd0);
        send_item(CMD_READ, '0, '0, '0, 10'd1);
        send_item(CMD_READ, '0, '0, '0, 10'd2);
        send_item(CMD_READ, '0, '0, '0, 10'd1023);
    endtask

    task automatic test_unused_and_clear();
        send_item(CMD_UNUSED, $urandom, $urandom, $urandom, $urandom_range(0, 1023));
        send_item(CMD_CLEAR, $urandom, $urandom, $urandom, $urandom_range(0, 1023));
        send_item(CMD_READ, '0, '0, '0, 10'd2);
    endtask

    task automatic test_capacity_clamp();
        write_capacity(11'd0);
        send_item(CMD_INSERT, $urandom, $urandom, $urandom, 10'd0);
        send_item(CMD_INSERT, $urandom, $urandom, $urandom, 10'd0);
        send_item(CMD_READ, '0, '0, '0, 10'd0);
        send_item(CMD_READ, '0, '0, '0, 10'd1);
        send_item(CMD_READ, '0, '0, '0, 10'd1023);
        write_capacity(11'h7FF);
        send_item(CMD_READ, '0, '0, '0, 10'd1023);
        send_item(CMD_INSERT, 32'd2047, $urandom, $urandom, 10'd0);
    endtask

    task automatic test_full_and_shrink();
        write_capacity(11'd3);
        repeat (3) send_item(CMD_INSERT, 32'd5, $urandom, $urandom, 10'd0);
        // entry in slot 1 stays but drops out of range
        write_capacity(11'd1);
        send_item(CMD_READ, '0, '0, '0, 10'd0);
        send_item(CMD_READ, '0, '0, '0, 10'd1);
        write_capacity(11'd1024);
        send_item(CMD_READ, '0, '0, '0, 10'd1);
    endtask

    task automatic test_random_traffic(input int idle_pct, input int n_phases);
        int unsigned      cap;
        int unsigned      pick;
        logic [CFG_W-1:0] cap_val;
        logic [KEY_W-1:0] key;
        logic [SLOT_W-1:0] rs;
        int               p;
        int               i;
        sender_idle_pct = idle_pct;
        for (p = 0; p < n_phases; p++)
        begin
            pick = $urandom_range(0, 9);
            if (pick < 4)
                cap_val = $urandom_range(1, 8);
            else if (pick < 6)
                cap_val = $urandom_range(9, 64);
            else if (pick == 6)
                cap_val = $urandom_range(65, 1023);
            else if (pick == 7)
                cap_val = 11'd1024;
            else if (pick == 8)
                cap_val = ($urandom_range(0, 1) != 0) ? 11'd0 : $urandom_range(1025, 2047);
            else
                cap_val = $urandom_range(2, 16);
            write_capacity(cap_val);
            cap = effective_capacity();
            for (i = 0; i < PHASE_ITEMS; i++)
            begin
                if ($urandom_range(0, 99) < 2)
                    wait_idle();
                pick = $urandom_range(0, 99);
                if (pick < 55)
                begin
                    case ($urandom_range(0, 3))
                        0: key = $urandom;
                        1: key = $urandom_range(0, 4 * cap);
                        // pile keys onto the first few home slots
                        2: key = cap * $urandom_range(0, 4000) + $urandom_range(0, 2);
                        default: key = 32'hFFFF_FFFF - $urandom_range(0, 7);
                    endcase
                    send_item(CMD_INSERT, key, $urandom, $urandom, $urandom_range(0, 1023));
                end
                else if (pick < 91)
                begin
                    if ($urandom_range(0, 3) != 0)
                        rs = $urandom_range(0, cap - 1);
                    else
                        rs = $urandom_range(0, 1023);
                    send_item(CMD_READ, $urandom, $urandom, $urandom, rs);
                end
                else if (pick < 94)
                    send_item(CMD_CLEAR, $urandom, $urandom, $urandom, $urandom_range(0, 1023));
                else
                    send_item(CMD_UNUSED, $urandom, $urandom, $urandom, $urandom_range(0, 1023));
            end
        end
    endtask

    always @(posedge clk)
    begin
        if (rst_n && done)
        begin
            observed.status   = status;
            observed.slot     = slot;
            observed.probes   = probes;
            observed.occupied = occupied;
            observed.va       = out_value_a;
            observed.vb       = out_value_b;
            observed.num      = entry_number;
            if (predicted_results.size() == 0)
            begin
                result_errors++;
                if (result_errors <= 10)
                    $display("%0t: result with none expected: %s", $time,
                             show_result(observed));
            end
            else
            begin
                wanted = predicted_results.pop_front();
                if (observed !== wanted)
                begin
                    result_errors++;
                    if (result_errors <= 10)
                        $display("%0t: mismatch\n  exp %s\n  got %s", $time,
                                 show_result(wanted), show_result(observed));
                end
            end
        end
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > MAX_CYCLES)
        begin
            $display("FAILURE");
            $finish;
        end
    end

    initial
    begin
        rst_n     = 1'b0;
        start     = 1'b0;
        cmd       = CMD_INSERT;
        hash_key  = '0;
        value_a   = '0;
        value_b   = '0;
        read_slot = '0;
        psel      = 1'b0;
        penable   = 1'b0;
        pwrite    = 1'b0;
        paddr     = ADDR_CAPACITY;
        pwdata    = '0;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;

        test_empty_reads();
        test_probe_wrap();
        test_unused_and_clear();
        test_capacity_clamp();
        test_full_and_shrink();
        test_random_traffic(27, 5);
        test_random_traffic(67, 5);
        test_random_traffic(0, 5);

        wait_idle();
        repeat (64) @(posedge clk);
        if (result_errors == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule

// ----- linear_probe_hash_insert_top.f -----
design/lphi_pkg.sv
design/lphi_front.sv
design/lphi_queue.sv
design/lphi_back.sv
design/linear_probe_hash_insert_top.sv
tb/tb_linear_probe_hash_insert_top.sv
